FILE: sv/itfv_pkg.sv
// Package for the IPv4 transport frame validator: payload types, error codes,
// parse modes, protocol constants and the ones'-complement add helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package itfv_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [7:0]  ip_protocol;
      logic [5:0]  ip_header_bytes;
      logic [5:0]  transport_header_bytes;
      logic [7:0]  payload_offset;
      logic [15:0] payload_bytes;
   } rsp_type;

   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_TRUNC     = 4'd1;
   localparam logic [3:0] ERR_NOT_IPV4  = 4'd2;
   localparam logic [3:0] ERR_VERSION   = 4'd3;
   localparam logic [3:0] ERR_HDR_LEN   = 4'd4;
   localparam logic [3:0] ERR_DECL_LEN  = 4'd5;
   localparam logic [3:0] ERR_FRAGMENT  = 4'd6;
   localparam logic [3:0] ERR_CHECKSUM  = 4'd7;
   localparam logic [3:0] ERR_PROTOCOL  = 4'd8;
   localparam logic [3:0] ERR_TRANS_LEN = 4'd9;

   localparam logic [1:0] MODE_IPV4 = 2'd0;
   localparam logic [1:0] MODE_ICMP = 2'd1;
   localparam logic [1:0] MODE_UDP  = 2'd2;
   localparam logic [1:0] MODE_TCP  = 2'd3;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   typedef struct packed {
      logic [15:0] ethertype_word;
      logic [7:0]  version_ihl;
      logic [15:0] total_length;
      logic [15:0] fragment_word;
      logic [7:0]  protocol_byte;
      logic [7:0]  tcp_offset_byte;
      logic [15:0] udp_length;
      logic        udp_sum_nonzero;
      logic [15:0] header_sum;
      logic [15:0] transport_sum;
      logic [15:0] pseudo_sum;
      logic [15:0] udp_sum;
   } frame_type;

   function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, x};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage
`default_nettype wire

FILE: sv/ipv4_transport_frame_validator_unit.sv
// Top level of the IPv4 transport frame validator.
// Depends on itfv_pkg, itfv_accum and itfv_verdict.
//
// Takes one Ethernet frame byte per transaction, starting at the destination
// MAC, and returns one verdict transaction for each byte marked last. A byte
// is accepted every cycle; the verdict appears in the result register in the
// cycle after its last byte is accepted and may wait there while further bytes
// keep arriving, since only a byte marked last is stalled, and only while that
// register is full and stalled.
// The parse mode register is sampled with the last byte of each frame.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_transport_frame_validator_unit #(
   parameter int COUNT_BITS = 17
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire itfv_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output itfv_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_data
);
   logic [1:0] mode_ff;
   logic [COUNT_BITS-1:0] len;
   itfv_pkg::frame_type fr;
   itfv_pkg::rsp_type verdict, rsp_ff;
   logic valid_ff, step;

   assign req_stall = valid_ff && rsp_stall && req_data.last_byte;
   assign step = req_valid && !req_stall;

   itfv_accum #(.COUNT_BITS(COUNT_BITS)) u_accum (
      .clock(clock), .reset(reset), .step(step), .b(req_data.data_byte),
      .last(req_data.last_byte), .count_out(len), .frame_out(fr)
   );

   itfv_verdict #(.COUNT_BITS(COUNT_BITS)) u_verdict (
      .len(len), .fr(fr), .mode(mode_ff), .rsp(verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= itfv_pkg::MODE_IPV4;
         valid_ff <= 1'b0;
      end else begin
         if (csr_write) mode_ff <= csr_data;
         if (step && req_data.last_byte) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
      if (step && req_data.last_byte) rsp_ff <= verdict;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

FILE: sv/itfv_accum.sv
// Per-byte capture and checksum accumulation stage of the frame validator.
// Depends on itfv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itfv_accum #(
   parameter int COUNT_BITS = 17
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              b,
   input  wire logic                    last,
   output logic [COUNT_BITS-1:0]        count_out,
   output itfv_pkg::frame_type          frame_out
);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [COUNT_BITS-1:0] count_ff, count_in;
   itfv_pkg::frame_type   fr_ff, fr_in;
   logic [7:0]            high_ff, high_in;

   logic [COUNT_BITS-1:0] o, s, r;
   logic [15:0] w, word;
   logic [7:0]  vihl;
   logic [15:0] tl;
   logic [5:0]  hl;
   logic        in_rng;
   logic [15:0] pl;

   always_comb begin
      o = count_ff;
      w = o[0] ? {8'd0, b} : {b, 8'd0};
      word = {high_ff, b};
      vihl = (o == COUNT_BITS'(14)) ? b : fr_ff.version_ihl;
      tl = (o == COUNT_BITS'(17)) ? word : fr_ff.total_length;
      hl = {vihl[3:0], 2'b00};
      s = COUNT_BITS'(14) + COUNT_BITS'(hl);
      r = o - s;
      pl = tl - {10'd0, hl};
      in_rng = 1'b0;
      count_in = count_ff;
      fr_in = fr_ff;
      high_in = high_ff;
      if (count_ff != COUNT_MAX) begin
         count_in = count_ff + 1'b1;
         if (!o[0]) high_in = b;
         if (o == COUNT_BITS'(13)) fr_in.ethertype_word = word;
         if (o == COUNT_BITS'(14)) fr_in.version_ihl = b;
         if (o == COUNT_BITS'(17)) fr_in.total_length = word;
         if (o == COUNT_BITS'(21)) fr_in.fragment_word = word;
         if (o == COUNT_BITS'(23)) fr_in.protocol_byte = b;
         if (o >= COUNT_BITS'(26) && o < COUNT_BITS'(34))
            fr_in.pseudo_sum = itfv_pkg::oc_add(fr_ff.pseudo_sum, w);
         if (o >= COUNT_BITS'(14) && (o - COUNT_BITS'(14)) < COUNT_BITS'(hl))
            fr_in.header_sum = itfv_pkg::oc_add(fr_ff.header_sum, w);
         if (o >= s) begin
            if (r == COUNT_BITS'(5)) fr_in.udp_length = word;
            if (r == COUNT_BITS'(7)) fr_in.udp_sum_nonzero = (word != 16'd0);
            if (r == COUNT_BITS'(12)) fr_in.tcp_offset_byte = b;
            in_rng = (tl >= {10'd0, hl}) &&
                     ({{(COUNT_BITS-15){1'b0}}, pl} > {1'b0, r});
            if (in_rng)
               fr_in.transport_sum = itfv_pkg::oc_add(fr_ff.transport_sum, w);
            if (r < COUNT_BITS'(6) ||
                {1'b0, r} < {{(COUNT_BITS-15){1'b0}}, fr_ff.udp_length})
               fr_in.udp_sum = itfv_pkg::oc_add(fr_ff.udp_sum, w);
         end
      end
      count_out = count_in;
      frame_out = fr_in;
      if (last) begin
         count_in = '0;
         fr_in = '0;
         high_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fr_ff <= '0;
         high_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
         fr_ff <= fr_in;
         high_ff <= high_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/itfv_verdict.sv
// Final verdict logic: ordered checks on the captured frame state.
// Depends on itfv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itfv_verdict #(
   parameter int COUNT_BITS = 17
) (
   input  wire logic [COUNT_BITS-1:0] len,
   input  wire itfv_pkg::frame_type   fr,
   input  wire logic [1:0]            mode,
   output itfv_pkg::rsp_type          rsp
);
   localparam int LW = COUNT_BITS + 1;
   logic [LW-1:0] l, tl, hlw;
   logic [5:0]  hl, th;
   logic [15:0] pl, sum, pbytes;
   logic [5:0]  thl;
   logic [3:0]  err;

   always_comb begin
      l = LW'(len);
      tl = LW'(fr.total_length);
      hl = {fr.version_ihl[3:0], 2'b00};
      hlw = LW'(hl);
      th = {fr.tcp_offset_byte[7:4], 2'b00};
      pl = fr.total_length - {10'd0, hl};
      err = itfv_pkg::ERR_OK;
      thl = '0;
      pbytes = '0;
      sum = '0;
      if (l < LW'(14)) err = itfv_pkg::ERR_TRUNC;
      else if (fr.ethertype_word != itfv_pkg::ETHERTYPE_IPV4) err = itfv_pkg::ERR_NOT_IPV4;
      else if (l < LW'(34)) err = itfv_pkg::ERR_TRUNC;
      else if (fr.version_ihl[7:4] != 4'd4) err = itfv_pkg::ERR_VERSION;
      else if (hl < 6'd20) err = itfv_pkg::ERR_HDR_LEN;
      else if (l < LW'(14) + hlw) err = itfv_pkg::ERR_TRUNC;
      else if (tl < hlw) err = itfv_pkg::ERR_DECL_LEN;
      else if (tl > l - LW'(14)) err = itfv_pkg::ERR_TRUNC;
      else if (fr.fragment_word[13:0] != 14'd0) err = itfv_pkg::ERR_FRAGMENT;
      else if (fr.header_sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
      else begin
         case (mode)
            itfv_pkg::MODE_IPV4: pbytes = pl;
            itfv_pkg::MODE_ICMP: begin
               if (fr.protocol_byte != itfv_pkg::PROTO_ICMP) err = itfv_pkg::ERR_PROTOCOL;
               else if (pl < 16'd8) err = itfv_pkg::ERR_TRANS_LEN;
               else if (fr.transport_sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
               else begin thl = 6'd8; pbytes = pl - 16'd8; end
            end
            itfv_pkg::MODE_UDP: begin
               sum = itfv_pkg::oc_add(itfv_pkg::oc_add(itfv_pkg::oc_add(fr.pseudo_sum,
                        {8'd0, fr.protocol_byte}), fr.udp_length), fr.udp_sum);
               if (fr.protocol_byte != itfv_pkg::PROTO_UDP) err = itfv_pkg::ERR_PROTOCOL;
               else if (pl < 16'd8) err = itfv_pkg::ERR_TRANS_LEN;
               else if (fr.udp_length < 16'd8 || fr.udp_length > pl)
                  err = itfv_pkg::ERR_TRANS_LEN;
               else if (fr.udp_sum_nonzero && sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
               else begin thl = 6'd8; pbytes = fr.udp_length - 16'd8; end
            end
            default: begin
               sum = itfv_pkg::oc_add(itfv_pkg::oc_add(itfv_pkg::oc_add(fr.pseudo_sum,
                        {8'd0, fr.protocol_byte}), pl), fr.transport_sum);
               if (fr.protocol_byte != itfv_pkg::PROTO_TCP) err = itfv_pkg::ERR_PROTOCOL;
               else if (pl < 16'd20) err = itfv_pkg::ERR_TRANS_LEN;
               else if (th < 6'd20 || {10'd0, th} > pl) err = itfv_pkg::ERR_TRANS_LEN;
               else if (sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
               else begin thl = th; pbytes = pl - {10'd0, th}; end
            end
         endcase
      end
      rsp = '0;
      rsp.error_code = err;
      if (err == itfv_pkg::ERR_OK) begin
         rsp.ip_protocol = fr.protocol_byte;
         rsp.ip_header_bytes = hl;
         rsp.transport_header_bytes = thl;
         rsp.payload_offset = 8'd14 + {2'b00, hl} + {2'b00, thl};
         rsp.payload_bytes = pbytes;
      end
   end
endmodule
`default_nettype wire

FILE: sv/itfv_checker.sv
// Port-level checker for the frame validator, bound to the top level.
// Depends on itfv_pkg and ipv4_transport_frame_validator_unit.
`timescale 1ns / 1ps
`default_nettype none
module itfv_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire itfv_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire itfv_pkg::rsp_type rsp_data
);
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_byte |=> rsp_valid)
      else $error("verdict missing after last byte");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled verdict changed");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != itfv_pkg::ERR_OK |->
      rsp_data.payload_bytes == 16'd0 && rsp_data.ip_header_bytes == 6'd0)
      else $error("fields not cleared on error");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.error_code <= itfv_pkg::ERR_TRANS_LEN)
      else $error("error code out of range");
endmodule

bind ipv4_transport_frame_validator_unit itfv_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
`default_nettype wire

FILE: tb/ipv4_transport_frame_validator_unit_tb.sv
// Self-checking testbench for ipv4_transport_frame_validator_unit: directed and random
// Ethernet frames, checked against a byte-level behavioral predictor of the verdict.
// Depends on itfv_pkg and the validator RTL.
`timescale 1ns / 1ps
module ipv4_transport_frame_validator_unit_tb;

   localparam int unsigned COUNT_MAX = (1 << 17) - 1;

   typedef enum int {
      FK_GOOD, FK_ONE_BYTE, FK_SHORT, FK_ETHERTYPE, FK_VERSION, FK_IHL, FK_DECL_LEN,
      FK_FRAGMENT, FK_HDR_CSUM, FK_TRANS_CSUM, FK_TRANS_LEN, FK_ZERO_ICMP
   } frame_kind_type;

   typedef struct {
      logic [1:0]     mode;
      logic [1:0]     body;
      frame_kind_type kind;
      bit             typed;
      logic [3:0]     err;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   itfv_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   itfv_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_data = '0;

   ipv4_transport_frame_validator_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   itfv_pkg::rsp_type verdict_q[$];
   bit [7:0] frame_bytes[$];
   int mismatches = 0;
   int verdicts_seen = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   bit idle_on = 1'b1;
   bit typed_valid = 1'b0;
   logic [3:0] typed_err;
   int stall_left = 0;

   logic [1:0] cur_mode;
   int unsigned cnt, eth, vihl, tot_len, frag, proto, tcp_off, udp_len, udp_nz;
   int unsigned hdr_sum, trn_sum, pseudo, udp_sum, hold;

   function automatic int unsigned add16(int unsigned s, int unsigned x);
      int unsigned t;
      t = s + (x & 32'hFFFF);
      return (t & 32'hFFFF) + (t >> 16);
   endfunction

   function automatic void clear_state();
      cnt = 0; eth = 0; vihl = 0; tot_len = 0; frag = 0; proto = 0; tcp_off = 0;
      udp_len = 0; udp_nz = 0; hdr_sum = 0; trn_sum = 0; pseudo = 0; udp_sum = 0;
      hold = 0;
   endfunction

   function automatic void absorb_byte(int unsigned o, int unsigned b);
      int unsigned w, word, hl, s, r;
      w = o[0] ? b : (b << 8);
      word = (hold << 8) | b;
      if (!o[0]) hold = b;
      if (o == 13) eth = word;
      if (o == 14) vihl = b;
      if (o == 17) tot_len = word;
      if (o == 21) frag = word;
      if (o == 23) proto = b;
      if (o >= 26 && o < 34) pseudo = add16(pseudo, w);
      hl = (vihl & 15) * 4;
      if (o >= 14 && o - 14 < hl) hdr_sum = add16(hdr_sum, w);
      s = 14 + hl;
      if (o >= s) begin
         r = o - s;
         if (r == 5) udp_len = word;
         if (r == 7) udp_nz = (word != 0);
         if (r == 12) tcp_off = b;
         if (tot_len >= hl && r < tot_len - hl) trn_sum = add16(trn_sum, w);
         if (r < 6 || r < udp_len) udp_sum = add16(udp_sum, w);
      end
   endfunction

   function automatic itfv_pkg::rsp_type frame_verdict();
      itfv_pkg::rsp_type v;
      int unsigned len, hl, pl, th, thl, pb, sum;
      logic [3:0] err;
      v = '0; err = itfv_pkg::ERR_OK; thl = 0; pb = 0;
      len = cnt;
      hl = (vihl & 15) * 4;
      pl = tot_len - hl;
      th = (tcp_off >> 4) * 4;
      if (len < 14) err = itfv_pkg::ERR_TRUNC;
      else if (eth != itfv_pkg::ETHERTYPE_IPV4) err = itfv_pkg::ERR_NOT_IPV4;
      else if (len < 34) err = itfv_pkg::ERR_TRUNC;
      else if ((vihl >> 4) != 4) err = itfv_pkg::ERR_VERSION;
      else if (hl < 20) err = itfv_pkg::ERR_HDR_LEN;
      else if (len < 14 + hl) err = itfv_pkg::ERR_TRUNC;
      else if (tot_len < hl) err = itfv_pkg::ERR_DECL_LEN;
      else if (tot_len > len - 14) err = itfv_pkg::ERR_TRUNC;
      else if ((frag & 16'h3FFF) != 0) err = itfv_pkg::ERR_FRAGMENT;
      else if (hdr_sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
      else if (cur_mode == itfv_pkg::MODE_IPV4) pb = pl;
      else if (cur_mode == itfv_pkg::MODE_ICMP) begin
         if (proto != itfv_pkg::PROTO_ICMP) err = itfv_pkg::ERR_PROTOCOL;
         else if (pl < 8) err = itfv_pkg::ERR_TRANS_LEN;
         else if (trn_sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
         else begin thl = 8; pb = pl - 8; end
      end else if (cur_mode == itfv_pkg::MODE_UDP) begin
         if (proto != itfv_pkg::PROTO_UDP) err = itfv_pkg::ERR_PROTOCOL;
         else if (pl < 8 || udp_len < 8 || udp_len > pl) err = itfv_pkg::ERR_TRANS_LEN;
         else begin
            sum = add16(add16(add16(pseudo, proto), udp_len), udp_sum);
            if (udp_nz && sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
            else begin thl = 8; pb = udp_len - 8; end
         end
      end else begin
         if (proto != itfv_pkg::PROTO_TCP) err = itfv_pkg::ERR_PROTOCOL;
         else if (pl < 20 || th < 20 || th > pl) err = itfv_pkg::ERR_TRANS_LEN;
         else begin
            sum = add16(add16(add16(pseudo, proto), pl), trn_sum);
            if (sum != 16'hFFFF) err = itfv_pkg::ERR_CHECKSUM;
            else begin thl = th; pb = pl - th; end
         end
      end
      v.error_code = err;
      if (err == itfv_pkg::ERR_OK) begin
         v.ip_protocol = proto[7:0];
         v.ip_header_bytes = hl[5:0];
         v.transport_header_bytes = thl[5:0];
         v.payload_offset = 8'(14 + hl + thl);
         v.payload_bytes = pb[15:0];
      end
      return v;
   endfunction

   function automatic int unsigned sum_range(int start, int n);
      int unsigned acc;
      int o;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         o = start + i;
         acc = add16(acc, o[0] ? frame_bytes[o] : (frame_bytes[o] << 8));
      end
      return acc;
   endfunction

   function automatic void put16(int o, int unsigned v);
      frame_bytes[o] = v[15:8];
      frame_bytes[o + 1] = v[7:0];
   endfunction

   function automatic void build_frame(logic [1:0] body, frame_kind_type kind);
      int ihl, hl, th, plen, tl, ts, ck_at;
      int unsigned s, ck;
      logic [7:0] pr;
      frame_bytes.delete();
      if (kind == FK_ONE_BYTE) begin
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      repeat (12) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'h08);
      frame_bytes.push_back(8'h00);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      hl = ihl * 4;
      case (body)
         itfv_pkg::MODE_IPV4: begin pr = 8'($urandom_range(0, 255)); th = 0; end
         itfv_pkg::MODE_ICMP: begin pr = itfv_pkg::PROTO_ICMP; th = 8; end
         itfv_pkg::MODE_UDP: begin pr = itfv_pkg::PROTO_UDP; th = 8; end
         default: begin
            pr = itfv_pkg::PROTO_TCP;
            th = ($urandom_range(0, 3) == 0) ? 4 * $urandom_range(5, 15) : 20;
         end
      endcase
      plen = $urandom_range(0, 24);
      tl = hl + th + plen;
      frame_bytes.push_back(8'h40 | 8'(ihl));
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(8'(tl >> 8));
      frame_bytes.push_back(8'(tl));
      repeat (2) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back({2'($urandom_range(0, 3)), 6'd0});
      frame_bytes.push_back(8'd0);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(pr);
      repeat (2) frame_bytes.push_back(8'd0);
      repeat (8 + hl - 20) frame_bytes.push_back(8'($urandom_range(0, 255)));
      ts = 14 + hl;
      repeat (th + plen)
         frame_bytes.push_back(kind == FK_ZERO_ICMP ? 8'd0 : 8'($urandom_range(0, 255)));
      ck_at = -1;
      if (body == itfv_pkg::MODE_ICMP) begin
         ck_at = ts + 2;
         put16(ck_at, 0);
         s = sum_range(ts, th + plen);
      end else if (body == itfv_pkg::MODE_UDP) begin
         ck_at = ts + 6;
         put16(ts + 4, th + plen);
         put16(ck_at, 0);
         s = add16(add16(add16(sum_range(26, 8), itfv_pkg::PROTO_UDP), th + plen),
                   sum_range(ts, th + plen));
      end else if (body == itfv_pkg::MODE_TCP) begin
         ck_at = ts + 16;
         frame_bytes[ts + 12] = {4'(th / 4), 4'($urandom_range(0, 15))};
         put16(ck_at, 0);
         s = add16(add16(add16(sum_range(26, 8), itfv_pkg::PROTO_TCP), th + plen),
                   sum_range(ts, th + plen));
      end
      if (ck_at >= 0 && kind != FK_ZERO_ICMP) begin
         ck = ~s & 16'hFFFF;
         if (kind == FK_TRANS_CSUM) ck = ((ck ^ 1) == 0) ? ck ^ 2 : ck ^ 1;
         put16(ck_at, ck);
      end
      case (kind)
         FK_VERSION: frame_bytes[14] = 8'h60 | 8'(ihl);
         FK_IHL: frame_bytes[14] = 8'h44;
         FK_DECL_LEN: put16(16, 10);
         FK_FRAGMENT: frame_bytes[21] = 8'($urandom_range(1, 255));
         FK_TRANS_LEN: put16(16, hl + 4);
         default: ;
      endcase
      s = ~sum_range(14, hl) & 16'hFFFF;
      put16(24, kind == FK_HDR_CSUM ? s ^ 1 : s);
      if (kind == FK_ETHERTYPE) frame_bytes[12] = 8'h86;
      repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (kind == FK_SHORT)
         while (frame_bytes.size() > 20) void'(frame_bytes.pop_back());
   endfunction

   task automatic send_byte(logic [7:0] b, logic last);
      itfv_pkg::rsp_type v;
      if (idle_on && $urandom_range(0, 15) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (cnt < COUNT_MAX) begin
         absorb_byte(cnt, b);
         cnt++;
      end
      if (last) begin
         v = frame_verdict();
         if (typed_valid) v = '{error_code: typed_err, default: '0};
         verdict_q.push_back(v);
         clear_state();
         frames_sent++;
      end
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   task automatic write_mode(logic [1:0] m);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      cur_mode = m;
      csr_write <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      itfv_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected verdict transaction: %p", rsp_data);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_data.error_code !== want.error_code
                || rsp_data.ip_protocol !== want.ip_protocol
                || rsp_data.ip_header_bytes !== want.ip_header_bytes
                || rsp_data.transport_header_bytes !== want.transport_header_bytes
                || rsp_data.payload_offset !== want.payload_offset
                || rsp_data.payload_bytes !== want.payload_bytes) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Verdict mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Timed out with %0d verdicts outstanding.", verdict_q.size());
      $display("ipv4_transport_frame_validator_unit: mismatch");
      $finish;
   end

   initial begin
      directed_row_type rows[$];
      logic [1:0] m;
      int k;
      rows = '{
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_GOOD, 0, itfv_pkg::ERR_OK},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_ONE_BYTE, 1, itfv_pkg::ERR_TRUNC},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_UDP, FK_SHORT, 1, itfv_pkg::ERR_TRUNC},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_ETHERTYPE, 1,
           itfv_pkg::ERR_NOT_IPV4},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_VERSION, 1, itfv_pkg::ERR_VERSION},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_IHL, 1, itfv_pkg::ERR_HDR_LEN},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_DECL_LEN, 1,
           itfv_pkg::ERR_DECL_LEN},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_TCP, FK_FRAGMENT, 1, itfv_pkg::ERR_FRAGMENT},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_IPV4, FK_HDR_CSUM, 1,
           itfv_pkg::ERR_CHECKSUM},
         '{itfv_pkg::MODE_IPV4, itfv_pkg::MODE_TCP, FK_GOOD, 0, itfv_pkg::ERR_OK},
         '{itfv_pkg::MODE_ICMP, itfv_pkg::MODE_ICMP, FK_GOOD, 0, itfv_pkg::ERR_OK},
         '{itfv_pkg::MODE_ICMP, itfv_pkg::MODE_ICMP, FK_TRANS_LEN, 1,
           itfv_pkg::ERR_TRANS_LEN},
         '{itfv_pkg::MODE_ICMP, itfv_pkg::MODE_ICMP, FK_ZERO_ICMP, 1,
           itfv_pkg::ERR_CHECKSUM},
         '{itfv_pkg::MODE_ICMP, itfv_pkg::MODE_ICMP, FK_TRANS_CSUM, 1,
           itfv_pkg::ERR_CHECKSUM},
         '{itfv_pkg::MODE_UDP, itfv_pkg::MODE_UDP, FK_GOOD, 0, itfv_pkg::ERR_OK},
         '{itfv_pkg::MODE_UDP, itfv_pkg::MODE_TCP, FK_GOOD, 1, itfv_pkg::ERR_PROTOCOL},
         '{itfv_pkg::MODE_UDP, itfv_pkg::MODE_UDP, FK_TRANS_CSUM, 1,
           itfv_pkg::ERR_CHECKSUM},
         '{itfv_pkg::MODE_TCP, itfv_pkg::MODE_TCP, FK_GOOD, 0, itfv_pkg::ERR_OK},
         '{itfv_pkg::MODE_TCP, itfv_pkg::MODE_TCP, FK_TRANS_CSUM, 1,
           itfv_pkg::ERR_CHECKSUM},
         '{itfv_pkg::MODE_TCP, itfv_pkg::MODE_UDP, FK_GOOD, 1, itfv_pkg::ERR_PROTOCOL}
      };
      cur_mode = itfv_pkg::MODE_IPV4;
      clear_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (i == 0 || rows[i].mode != cur_mode) write_mode(rows[i].mode);
         build_frame(rows[i].body, rows[i].kind);
         typed_valid = rows[i].typed;
         typed_err = rows[i].err;
         send_frame();
      end
      typed_valid = 1'b0;

      while (bytes_sent < 550 + 1200 || frames_sent < 80) begin
         write_mode(2'($urandom_range(0, 3)));
         repeat (6) begin
            if ($urandom_range(0, 6) == 0) begin
               frame_bytes.delete();
               repeat ($urandom_range(1, 60))
                  frame_bytes.push_back(8'($urandom_range(0, 255)));
               if (frame_bytes.size() > 14 && $urandom_range(0, 1)) begin
                  frame_bytes[12] = 8'h08;
                  frame_bytes[13] = 8'h00;
               end
            end else begin
               m = ($urandom_range(0, 9) < 7) ? cur_mode : 2'($urandom_range(0, 3));
               k = ($urandom_range(0, 9) < 7) ? FK_GOOD : $urandom_range(1, 11);
               build_frame(m, frame_kind_type'(k));
            end
            send_frame();
         end
      end

      idle_on = 1'b0;
      write_mode(itfv_pkg::MODE_IPV4);
      build_frame(itfv_pkg::MODE_UDP, FK_GOOD);
      for (int i = 0; i < frame_bytes.size(); i++) send_byte(frame_bytes[i], 1'b0);
      for (int i = frame_bytes.size(); i < COUNT_MAX + 6; i++)
         send_byte(8'($urandom_range(0, 255)), i == COUNT_MAX + 5);
      build_frame(itfv_pkg::MODE_IPV4, FK_GOOD);
      send_frame();
      req_valid <= 1'b0;

      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d frames under all four parse modes, including a frame",
               bytes_sent, frames_sent);
      $display("longer than the byte counter; %0d verdicts were checked.", verdicts_seen);
      if (mismatches == 0) begin
         $display("ipv4_transport_frame_validator_unit: match");
      end else begin
         $display("%0d verdicts disagreed.", mismatches);
         $display("ipv4_transport_frame_validator_unit: mismatch");
      end
      $finish;
   end

endmodule
